// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms on clk, with and without the reset guard.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while rst_n is high.
`define SMF_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every edge, also while reset is applied.
`define SMF_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/smf_pkg.sv
// ----------------------------------------------------------------------------
// smf_pkg
// Types shared by the mode finder, its cells and its stream interfaces.
// ----------------------------------------------------------------------------
package smf_pkg;

    localparam int unsigned KEY_W   = 32;
    localparam int unsigned COUNT_W = 16;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             last;
    } in_item_t;

    typedef struct packed {
        logic [KEY_W-1:0]   winner_key;
        logic [COUNT_W-1:0] winner_count;
        logic               table_overflow;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic last;
        logic any_hit;
    } cell_ctl_t;

endpackage

// File: hw/rtl/smf_if.sv
// ----------------------------------------------------------------------------
// smf_if
// Valid/ready stream channels for input keys and for set results.
// ----------------------------------------------------------------------------
interface smf_in_if;
    import smf_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface smf_out_if;
    import smf_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/smf_cell.sv
// ----------------------------------------------------------------------------
// smf_cell
// One table slot: holds a key and its count, matches the broadcast key and
// claims itself when it is the first free slot of the row.
// ----------------------------------------------------------------------------
module smf_cell #(
    parameter int unsigned KEY_BITS   = 32,
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  smf_pkg::cell_ctl_t    ctl,
    input  logic [KEY_BITS-1:0]   key,
    input  logic                  prev_valid,
    output logic                  valid,
    output logic                  match,
    output logic [COUNT_BITS-1:0] hit_count
);
    import smf_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    logic [KEY_BITS-1:0]   key_reg;
    logic [KEY_BITS-1:0]   key_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [COUNT_BITS-1:0] count_inc;
    logic                  alloc;

    always_comb
    begin
        count_inc = (count_reg == '1) ? count_reg : count_reg + COUNT_BITS'(1);
        match     = valid_reg && (key_reg == key);
        alloc     = !valid_reg && prev_valid && !ctl.any_hit;

        if (match)
        begin
            hit_count = count_inc;
        end
        else if (alloc)
        begin
            hit_count = COUNT_BITS'(1);
        end
        else
        begin
            hit_count = '0;
        end

        valid_next = valid_reg;
        key_next   = key_reg;
        count_next = count_reg;
        if (ctl.accept)
        begin
            if (ctl.last)
            begin
                valid_next = 1'b0;
            end
            else if (match)
            begin
                count_next = count_inc;
            end
            else if (alloc)
            begin
                valid_next = 1'b1;
                key_next   = key;
                count_next = COUNT_BITS'(1);
            end
        end
    end

    assign valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        count_reg <= count_next;
    end

endmodule

// File: hw/rtl/streaming_mode_finder.sv
// ----------------------------------------------------------------------------
// streaming_mode_finder
// Throughput: one key per cycle, but in_items.ready drops while stage 1 holds
// a last key and an untaken result; the cell row matches and counts each key
// in the cycle it is taken, with the running best one register stage later.
// Reset: cells empty, running best and overflow flag zero, no result pending.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module streaming_mode_finder #(
    parameter int unsigned TABLE_ENTRIES = 64,
    parameter int unsigned KEY_BITS      = 32,
    parameter int unsigned COUNT_BITS    = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    smf_in_if.sink    in_items,
    smf_out_if.source results
);
    import smf_pkg::*;

    logic [KEY_BITS-1:0]   key_in;
    logic                  in_fire;
    cell_ctl_t             ctl;
    logic [TABLE_ENTRIES-1:0] cell_valid;
    logic [TABLE_ENTRIES-1:0] cell_match;
    logic [COUNT_BITS-1:0] cell_count [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0] hit_count;
    logic                  drop;

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  s1_last_reg;
    logic                  s1_last_next;
    logic                  s1_drop_reg;
    logic                  s1_drop_next;
    logic [KEY_BITS-1:0]   s1_key_reg;
    logic [KEY_BITS-1:0]   s1_key_next;
    logic [COUNT_BITS-1:0] s1_count_reg;
    logic [COUNT_BITS-1:0] s1_count_next;
    logic                  s1_adv;
    logic                  s1_fire;

    logic [KEY_BITS-1:0]   best_key_reg;
    logic [KEY_BITS-1:0]   best_key_next;
    logic [COUNT_BITS-1:0] best_count_reg;
    logic [COUNT_BITS-1:0] best_count_next;
    logic                  overflow_reg;
    logic                  overflow_next;
    logic [KEY_BITS-1:0]   new_key;
    logic [COUNT_BITS-1:0] new_count;
    logic                  new_overflow;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    out_item_t             out_data_reg;
    out_item_t             out_data_next;

    assign key_in      = KEY_BITS'(64'(in_items.data.key));
    assign in_fire     = in_items.valid && in_items.ready;
    assign ctl.accept  = in_fire;
    assign ctl.last    = in_items.data.last;
    assign ctl.any_hit = |cell_match;

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        logic prev_valid;

        if (i == 0)
        begin : g_head
            assign prev_valid = 1'b1;
        end
        else
        begin : g_link
            assign prev_valid = cell_valid[i-1];
        end

        smf_cell #(
            .KEY_BITS  (KEY_BITS),
            .COUNT_BITS(COUNT_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .key       (key_in),
            .prev_valid(prev_valid),
            .valid     (cell_valid[i]),
            .match     (cell_match[i]),
            .hit_count (cell_count[i])
        );
    end

    always_comb
    begin
        hit_count = '0;
        for (int unsigned i = 0; i < TABLE_ENTRIES; i++)
        begin
            hit_count = hit_count | cell_count[i];
        end
    end

    assign drop = !ctl.any_hit && cell_valid[TABLE_ENTRIES-1];

    assign s1_adv  = !s1_valid_reg || !s1_last_reg || !out_valid_reg || results.ready;
    assign s1_fire = s1_valid_reg && s1_adv;
    assign in_items.ready = s1_adv;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_last_next  = s1_last_reg;
        s1_drop_next  = s1_drop_reg;
        s1_key_next   = s1_key_reg;
        s1_count_next = s1_count_reg;
        if (s1_adv)
        begin
            s1_valid_next = in_fire;
            s1_last_next  = in_items.data.last;
            s1_drop_next  = drop;
            s1_key_next   = key_in;
            s1_count_next = hit_count;
        end
    end

    always_comb
    begin
        if (!s1_drop_reg && (s1_count_reg > best_count_reg))
        begin
            new_key   = s1_key_reg;
            new_count = s1_count_reg;
        end
        else
        begin
            new_key   = best_key_reg;
            new_count = best_count_reg;
        end
        new_overflow = overflow_reg || s1_drop_reg;

        best_key_next   = best_key_reg;
        best_count_next = best_count_reg;
        overflow_next   = overflow_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        out_data_next   = out_data_reg;

        if (s1_fire)
        begin
            if (s1_last_reg)
            begin
                best_key_next   = '0;
                best_count_next = '0;
                overflow_next   = 1'b0;
                out_valid_next  = 1'b1;
                out_data_next.winner_key     = KEY_W'(64'(new_key));
                out_data_next.winner_count   = COUNT_W'(32'(new_count));
                out_data_next.table_overflow = new_overflow;
            end
            else
            begin
                best_key_next   = new_key;
                best_count_next = new_count;
                overflow_next   = new_overflow;
            end
        end
    end

    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            best_key_reg   <= '0;
            best_count_reg <= '0;
            overflow_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            best_key_reg   <= best_key_next;
            best_count_reg <= best_count_next;
            overflow_reg   <= overflow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_last_reg  <= s1_last_next;
        s1_drop_reg  <= s1_drop_next;
        s1_key_reg   <= s1_key_next;
        s1_count_reg <= s1_count_next;
        out_data_reg <= out_data_next;
    end

    // A key can live in at most one slot, and slots fill from the head.
    `SMF_ASSERT_ALWAYS(a_single_match, $onehot0(cell_match), "key matched several slots")
    `SMF_ASSERT(a_prefix_fill, ((cell_valid & (cell_valid + TABLE_ENTRIES'(1))) == '0), "slot gap")
    `SMF_ASSERT(a_counted, (s1_valid_reg && !s1_drop_reg) |-> (s1_count_reg != '0), "zero count")
    `SMF_ASSERT(a_set_clear, (s1_fire && s1_last_reg) |=> (best_count_reg == '0 && !overflow_reg), "best not cleared")

endmodule
